// File: hdl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// fpe_pkg
// shared widths, types and helpers of the frustum plane extractor
// ----------------------------------------------------------------------------
`default_nettype none
package fpe_pkg;
	localparam int DATA_W        = 32;
	localparam int IDX_W         = 4;
	localparam int PLANE_W       = 3;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CO_W          = 33;
	localparam int SQ_W          = 68;
	localparam int ROOT_W        = 34;
	localparam int LEN_W         = 35;
	localparam int REM_W         = 37;
	localparam logic [PLANE_W-1:0] LAST_PLANE = 3'd5;

	typedef struct packed {
		logic busy;
		logic done;
	} fpe_div_stat_t;

	function automatic logic [CO_W-1:0] mag(input logic signed [CO_W-1:0] v);
		mag = v[CO_W-1] ? CO_W'(-v) : CO_W'(v);
	endfunction
endpackage
`default_nettype wire

// File: hdl/fpe_divider.sv
// ----------------------------------------------------------------------------
// fpe_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fpe_divider #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 35
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     num,
	input  wire logic [DEN_W-1:0]     den,
	output fpe_pkg::fpe_div_stat_t    stat,
	output logic      [NUM_W-1:0]     quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   tr;
	logic             ge;
	logic [DEN_W:0]   diff;

	assign tr   = {rem_q, n_q[NUM_W-1]};
	assign ge   = tr >= {1'b0, den_q};
	assign diff = tr - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				rem_q <= ge ? diff[DEN_W-1:0] : tr[DEN_W-1:0];
				n_q   <= {n_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = n_q;
endmodule
`default_nettype wire

// File: hdl/frustum_plane_extractor_unit.sv
// ----------------------------------------------------------------------------
// frustum_plane_extractor_unit
// loads a 4x4 matrix and emits six normalized frustum planes
// ----------------------------------------------------------------------------
// a beat with index below 15 is only stored; index 15 starts the six planes, each
// with its normal squared by the bit-serial squarer, rooted by the bit-serial root,
// rounded, and its coefficients divided by the bit-serial divider (root and division
// skipped for a zero normal); input is stalled until the sixth plane has been loaded
// into the output register; reset clears control state; matrix entries are undefined until written
`default_nettype none
module frustum_plane_extractor_unit #(
	parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [fpe_pkg::DATA_W-1:0]   matrix_element,
	input  wire logic        [fpe_pkg::IDX_W-1:0]    element_index,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [fpe_pkg::PLANE_W-1:0]  plane_index,
	output logic signed      [fpe_pkg::DATA_W-1:0]   coef_a,
	output logic signed      [fpe_pkg::DATA_W-1:0]   coef_b,
	output logic signed      [fpe_pkg::DATA_W-1:0]   coef_c,
	output logic signed      [fpe_pkg::DATA_W-1:0]   coef_d,
	output logic                                     degenerate,
	output logic                                     last_plane
);
	localparam int DW     = fpe_pkg::DATA_W;
	localparam int CW     = fpe_pkg::CO_W;
	localparam int SW     = fpe_pkg::SQ_W;
	localparam int RW     = fpe_pkg::ROOT_W;
	localparam int LW     = fpe_pkg::LEN_W;
	localparam int MW     = fpe_pkg::REM_W;
	localparam int NUM_W  = CW + FRAC_BITS + 1;
	localparam int CNT_W  = 6;
	localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(CW - 1);
	localparam logic [CNT_W-1:0] RT_LAST = CNT_W'(RW - 1);
	localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(64'h7fffffff);
	localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(64'h80000000);

	typedef enum logic [3:0] {
		S_IDLE, S_FORM, S_SQLD, S_SQR, S_RTLD, S_ROOT, S_RND, S_DIVLD, S_DIVW, S_EMIT
	} state_t;

	state_t                         state_q;
	logic [DW-1:0]                  store_q [16];
	logic signed [CW-1:0]           co_q [4];
	logic signed [DW-1:0]           res_q [4];
	logic signed [CW-1:0]           w_q;
	logic [fpe_pkg::PLANE_W-1:0]    plane_q;
	logic [1:0]                     k_q;
	logic                           half_q;
	logic [CNT_W-1:0]               cnt_q;
	logic                           degen_q;
	logic [CW-1:0]                  msq_q;
	logic [SW-1:0]                  adq_q;
	logic [SW-1:0]                  acc_q;
	logic [SW-1:0]                  rad_q;
	logic [MW-1:0]                  rem_q;
	logic [RW-1:0]                  root_q;
	logic [LW-1:0]                  len_q;

	logic [fpe_pkg::IDX_W-1:0]      rd_addr;
	logic signed [CW-1:0]           rd_val;
	logic signed [CW-1:0]           co_k;
	logic [MW-1:0]                  remsh;
	logic [MW-1:0]                  trial;
	logic [NUM_W-1:0]               div_num;
	logic [NUM_W-1:0]               quot;
	fpe_pkg::fpe_div_stat_t         div_stat;
	logic [DW-1:0]                  sat_q;
	logic [DW-1:0]                  sat_d;
	logic                           emit_ok;

	assign in_stall = state_q != S_IDLE;
	assign rd_addr  = half_q ? {k_q, plane_q[2:1]} : {k_q, 2'b11};
	assign rd_val   = CW'(signed'(store_q[rd_addr]));
	assign co_k     = co_q[k_q];
	assign remsh    = {rem_q[MW-3:0], rad_q[SW-1:SW-2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign div_num  = (NUM_W'(fpe_pkg::mag(co_k)) << FRAC_BITS) + NUM_W'(len_q >> 1);
	assign emit_ok  = !out_valid || !out_stall;

	always_comb begin
		if (co_k[CW-1]) begin
			sat_q = (quot > NEG_MAX) ? 32'h80000000 : DW'(-quot);
		end else begin
			sat_q = (quot > POS_MAX) ? 32'h7fffffff : quot[DW-1:0];
		end
		if (co_q[3] > CW'(signed'(32'h7fffffff))) begin
			sat_d = 32'h7fffffff;
		end else if (co_q[3] < CW'(signed'(32'h80000000))) begin
			sat_d = 32'h80000000;
		end else begin
			sat_d = co_q[3][DW-1:0];
		end
	end

	fpe_divider #(
		.NUM_W(NUM_W),
		.DEN_W(LW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == S_DIVLD),
		.num   (div_num),
		.den   (len_q),
		.stat  (div_stat),
		.quot  (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			plane_q   <= '0;
			k_q       <= '0;
			half_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_EMIT) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						store_q[element_index] <= matrix_element;
						if (element_index == 4'd15) begin
							state_q <= S_FORM;
							plane_q <= '0;
							k_q     <= '0;
							half_q  <= 1'b0;
						end
					end
				end
				S_FORM: begin
					if (!half_q) begin
						w_q    <= rd_val;
						half_q <= 1'b1;
					end else begin
						co_q[k_q] <= plane_q[0] ? w_q - rd_val : w_q + rd_val;
						half_q    <= 1'b0;
						k_q       <= k_q + 1'b1;
						if (k_q == 2'd3) begin
							state_q <= S_SQLD;
							acc_q   <= '0;
						end
					end
				end
				S_SQLD: begin
					msq_q   <= fpe_pkg::mag(co_k);
					adq_q   <= SW'(fpe_pkg::mag(co_k));
					cnt_q   <= '0;
					state_q <= S_SQR;
				end
				S_SQR: begin
					if (msq_q[0]) begin
						acc_q <= acc_q + adq_q;
					end
					adq_q <= adq_q << 1;
					msq_q <= msq_q >> 1;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_LAST) begin
						if (k_q == 2'd2) begin
							state_q <= S_RTLD;
							k_q     <= '0;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SQLD;
						end
					end
				end
				S_RTLD: begin
					if (acc_q == '0) begin
						res_q[0] <= '0;
						res_q[1] <= '0;
						res_q[2] <= '0;
						res_q[3] <= sat_d;
						degen_q  <= 1'b1;
						state_q  <= S_EMIT;
					end else begin
						rad_q   <= acc_q;
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= '0;
						degen_q <= 1'b0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					rad_q <= rad_q << 2;
					if (remsh >= trial) begin
						rem_q  <= remsh - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q  <= remsh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == RT_LAST) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					len_q   <= LW'(root_q) + LW'(rem_q > MW'(root_q));
					k_q     <= '0;
					state_q <= S_DIVLD;
				end
				S_DIVLD: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_stat.done) begin
						res_q[k_q] <= sat_q;
						k_q        <= k_q + 1'b1;
						state_q    <= (k_q == 2'd3) ? S_EMIT : S_DIVLD;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						out_valid   <= 1'b1;
						plane_index <= plane_q;
						coef_a      <= res_q[0];
						coef_b      <= res_q[1];
						coef_c      <= res_q[2];
						coef_d      <= res_q[3];
						degenerate  <= degen_q;
						last_plane  <= plane_q == fpe_pkg::LAST_PLANE;
						k_q         <= '0;
						half_q      <= 1'b0;
						if (plane_q == fpe_pkg::LAST_PLANE) begin
							state_q <= S_IDLE;
						end else begin
							plane_q <= plane_q + 1'b1;
							state_q <= S_FORM;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hdl/fpe_checker.sv
// ----------------------------------------------------------------------------
// fpe_checker
// port-level checks of the frustum plane extractor
// ----------------------------------------------------------------------------
`default_nettype none
module fpe_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic [fpe_pkg::DATA_W-1:0]         matrix_element,
	input wire logic [fpe_pkg::IDX_W-1:0]          element_index,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [fpe_pkg::PLANE_W-1:0]        plane_index,
	input wire logic [fpe_pkg::DATA_W-1:0]         coef_a,
	input wire logic [fpe_pkg::DATA_W-1:0]         coef_b,
	input wire logic [fpe_pkg::DATA_W-1:0]         coef_c,
	input wire logic [fpe_pkg::DATA_W-1:0]         coef_d,
	input wire logic                               degenerate,
	input wire logic                               last_plane
);
	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coef_a) && $stable(plane_index))
		else $error("stalled result beat changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_plane == (plane_index == fpe_pkg::LAST_PLANE)))
		else $error("last_plane flag mismatch");

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> coef_a == '0 && coef_b == '0 && coef_c == '0)
		else $error("degenerate plane has nonzero normal");

	// a new plane beat follows its predecessor in order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_plane ##1 out_valid && !$stable(plane_index)
		|-> plane_index == $past(plane_index) + 3'd1)
		else $error("plane order broken");
endmodule

bind frustum_plane_extractor_unit fpe_checker u_fpe_checker (.*);
`default_nettype wire
